// ----- src/tlnvf_pkg.sv -----
// Shared types, constants and character helpers for the text filter.
`default_nettype none
package tlnvf_pkg;

    localparam int BUFFER_BYTES_DEF = 2048;
    localparam int QUEUE_DEPTH      = 4;
    localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 1;

    localparam logic [7:0]  CH_TAB     = 8'd9;
    localparam logic [7:0]  CH_NL      = 8'd10;
    localparam logic [7:0]  CH_SPACE   = 8'd32;
    localparam logic [7:0]  CH_DOLLAR  = 8'd36;
    localparam logic [7:0]  CH_DASH    = 8'd45;
    localparam logic [7:0]  CH_ZERO    = 8'd48;
    localparam logic [7:0]  CH_QUEST   = 8'd63;
    localparam logic [7:0]  CH_UPPER_I = 8'd73;
    localparam logic [7:0]  CH_UPPER_M = 8'd77;
    localparam logic [7:0]  CH_CARET   = 8'd94;
    localparam logic [6:0]  CH_DEL     = 7'd127;
    localparam logic [23:0] NUM_RESET  = 24'h000001;
    localparam logic [23:0] NUM_MAX    = 24'h999999;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUMBER_ALL      = 3'd0,
        CFG_NUMBER_NONBLANK = 3'd1,
        CFG_SQUEEZE_BLANK   = 3'd2,
        CFG_SHOW_ENDS       = 3'd3,
        CFG_SHOW_TABS       = 3'd4,
        CFG_SHOW_NONPRINT   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic number_all;
        logic number_nonblank;
        logic squeeze_blank;
        logic show_ends;
        logic show_tabs;
        logic show_nonprint;
    } t_cfg;

    // one classified input byte handed from front to back
    typedef struct packed {
        logic [7:0]  data;
        logic        numbered;
        logic [23:0] digits;
    } t_cmd;

    typedef struct packed {
        logic [3:0][7:0] ch;
        logic [2:0]      len;
    } t_body;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [23:0] bcd_bump(input logic [23:0] v);
        logic [23:0] r;
        logic        carry;
        r     = v;
        carry = 1'b1;
        if (v != NUM_MAX) begin
            for (int d = 0; d < 6; d++) begin
                if (carry) begin
                    if (v[4*d +: 4] < 4'd9) begin
                        r[4*d +: 4] = v[4*d +: 4] + 4'd1;
                        carry       = 1'b0;
                    end else begin
                        r[4*d +: 4] = 4'd0;
                    end
                end
            end
        end
        return r;
    endfunction

    // idx 0..5 are the six digit columns, idx 6 is the tab
    function automatic logic [7:0] num_char(input logic [23:0] digits, input logic [2:0] idx);
        logic [2:0] d;
        logic       nz;
        logic [7:0] c;
        d  = 3'd5 - idx;
        nz = 1'b0;
        for (int k = 0; k < 6; k++) begin
            if (3'(k) >= d && digits[4*k +: 4] != 4'd0) begin
                nz = 1'b1;
            end
        end
        if (idx == 3'd6) begin
            c = CH_TAB;
        end else if (!nz && idx != 3'd5) begin
            c = CH_SPACE;
        end else begin
            c = CH_ZERO + {4'd0, digits[4*d +: 4]};
        end
        return c;
    endfunction

    function automatic t_body body_chars(input logic [7:0] b, input t_cfg cfg);
        t_body      r;
        logic [6:0] lo;
        logic [2:0] p;
        r.ch  = '0;
        r.len = 3'd1;
        lo    = b[6:0];
        p     = 3'd0;
        if (b == CH_TAB && cfg.show_tabs) begin
            r.ch[0] = CH_CARET;
            r.ch[1] = CH_UPPER_I;
            r.len   = 3'd2;
        end else if (b == CH_NL) begin
            if (cfg.show_ends) begin
                r.ch[0] = CH_DOLLAR;
                r.ch[1] = CH_NL;
                r.len   = 3'd2;
            end else begin
                r.ch[0] = CH_NL;
            end
        end else if (cfg.show_nonprint && b != CH_TAB) begin
            if (b[7]) begin
                r.ch[0] = CH_UPPER_M;
                r.ch[1] = CH_DASH;
                p       = 3'd2;
            end
            if (lo == CH_DEL) begin
                r.ch[p[1:0]]        = CH_CARET;
                r.ch[p[1:0] + 2'd1] = CH_QUEST;
                r.len               = p + 3'd2;
            end else if (lo < 7'd32) begin
                r.ch[p[1:0]]        = CH_CARET;
                r.ch[p[1:0] + 2'd1] = {1'b0, lo} + 8'd64;
                r.len               = p + 3'd2;
            end else begin
                r.ch[p[1:0]] = {1'b0, lo};
                r.len        = p + 3'd1;
            end
        end else begin
            r.ch[0] = b;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- src/tlnvf_in_if.sv -----
// Input channel: one text byte per request.
`default_nettype none
interface tlnvf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       first_of_file;

    modport source (output valid, output in_byte, output first_of_file, input ready);
    modport sink   (input valid, input in_byte, input first_of_file, output ready);
endinterface
`default_nettype wire

// ----- src/tlnvf_out_if.sv -----
// Output channel: one character per request.
`default_nettype none
interface tlnvf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface
`default_nettype wire

// ----- src/tlnvf_front.sv -----
// Front end: chunk tracking, squeeze, line numbering decision.
`default_nettype none
module tlnvf_front
    import tlnvf_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire logic i_valid,
    input  wire logic [7:0] i_byte,
    input  wire logic i_first,
    input  wire logic i_q_full,
    output logic      o_ready,
    output logic      o_push,
    output t_cmd      o_cmd
);

    localparam int POS_W = $clog2(BUFFER_BYTES);

    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_prev, n_prev;
    logic [23:0]      r_digits, n_digits;

    logic [POS_W-1:0] pos;
    logic             prev;
    logic             at_start;
    logic             empty;
    logic             drop;
    logic             numbered;
    logic             take;

    assign o_ready = !i_q_full;
    assign take    = i_valid && o_ready;

    always_comb begin
        pos      = i_first ? '0 : r_pos;
        prev     = i_first ? 1'b0 : r_prev;
        at_start = (pos == '0);
        empty    = (i_byte == CH_NL);
        drop     = at_start && i_cfg.squeeze_blank && empty && prev;
        numbered = at_start && (i_cfg.number_nonblank ? !empty : i_cfg.number_all);

        n_pos    = r_pos;
        n_prev   = r_prev;
        n_digits = r_digits;
        if (take) begin
            n_pos  = pos;
            n_prev = prev;
            if (!drop) begin
                if (numbered) begin
                    n_digits = bcd_bump(r_digits);
                end
                if (at_start) begin
                    n_prev = empty;
                end
                // chunk ends at newline or when the buffer would fill
                if (empty || pos == POS_W'(BUFFER_BYTES - 2)) begin
                    n_pos = '0;
                end else begin
                    n_pos = pos + 1'b1;
                end
            end
        end
    end

    assign o_push         = take && !drop;
    assign o_cmd.data     = i_byte;
    assign o_cmd.numbered = numbered;
    assign o_cmd.digits   = r_digits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_prev   <= 1'b0;
            r_digits <= NUM_RESET;
        end else begin
            r_pos    <= n_pos;
            r_prev   <= n_prev;
            r_digits <= n_digits;
        end
    end

endmodule
`default_nettype wire

// ----- src/tlnvf_queue.sv -----
// Small queue of classified bytes between front and back.
`default_nettype none
module tlnvf_queue
    import tlnvf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_wdata,
    input  wire logic i_pop,
    output t_cmd      o_rdata,
    output t_q_stat   o_stat
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_cnt;

    assign o_rdata      = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- src/tlnvf_back.sv -----
// Back end: expands one classified byte into its output characters.
`default_nettype none
module tlnvf_back
    import tlnvf_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_cfg    i_cfg,
    input  wire t_cmd    i_cmd,
    input  wire t_q_stat i_q_stat,
    output logic         o_pop,
    output logic         o_valid,
    input  wire logic    i_ready,
    output logic [7:0]   o_byte,
    output logic         o_last
);

    logic       r_busy;
    t_cmd       r_cur;
    logic [3:0] r_idx;
    logic       r_ov;
    logic [7:0] r_ob;
    logic       r_ol;

    t_body      body;
    logic [3:0] num_len;
    logic [3:0] body_off;
    logic [7:0] ch;
    logic       last;
    logic       out_free;
    logic       emit;

    always_comb begin
        body     = body_chars(r_cur.data, i_cfg);
        num_len  = r_cur.numbered ? 4'd7 : 4'd0;
        body_off = r_idx - num_len;
        if (r_idx < num_len) begin
            ch = num_char(r_cur.digits, r_idx[2:0]);
        end else begin
            ch = body.ch[body_off[1:0]];
        end
        last = (r_idx == num_len + {1'b0, body.len} - 4'd1);
    end

    assign out_free = !r_ov || i_ready;
    assign emit     = r_busy && out_free;
    // refill in the cycle the last character leaves, so runs stay back to back
    assign o_pop    = !i_q_stat.empty && (!r_busy || (emit && last));

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_cmd;
        end
        if (out_free) begin
            r_ob <= ch;
            r_ol <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (out_free) begin
                r_ov <= emit;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (emit) begin
                if (last) begin
                    r_busy <= 1'b0;
                end
                r_idx <= r_idx + 4'd1;
            end
        end
    end

    assign o_valid = r_ov;
    assign o_byte  = r_ob;
    assign o_last  = r_ol;

endmodule
`default_nettype wire

// ----- src/text_line_number_visualize_filter.sv -----
// Path: an accepted byte is written to the queue, loaded into the back end's current-byte register,
// and its characters leave through the single-character output register, one per cycle while the
// receiver is ready; an input byte expands to 1 to 11 characters.
// Input is taken every cycle while the 4-entry queue has room.
// Reset: synchronous, active low; options cleared, line number back to 1, queue empty.
`default_nettype none
module text_line_number_visualize_filter
    import tlnvf_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    tlnvf_in_if.sink                   i_in,
    tlnvf_out_if.source                o_out,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    r_cfg;
    t_cmd    push_cmd;
    t_cmd    pop_cmd;
    t_q_stat q_stat;
    logic    q_push;
    logic    q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_NUMBER_ALL:      r_cfg.number_all      <= i_cfg_data[0];
                CFG_NUMBER_NONBLANK: r_cfg.number_nonblank <= i_cfg_data[0];
                CFG_SQUEEZE_BLANK:   r_cfg.squeeze_blank   <= i_cfg_data[0];
                CFG_SHOW_ENDS:       r_cfg.show_ends       <= i_cfg_data[0];
                CFG_SHOW_TABS:       r_cfg.show_tabs       <= i_cfg_data[0];
                CFG_SHOW_NONPRINT:   r_cfg.show_nonprint   <= i_cfg_data[0];
                default:             r_cfg                 <= r_cfg;
            endcase
        end
    end

    tlnvf_front #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_in.valid),
        .i_byte   (i_in.in_byte),
        .i_first  (i_in.first_of_file),
        .i_q_full (q_stat.full),
        .o_ready  (i_in.ready),
        .o_push   (q_push),
        .o_cmd    (push_cmd)
    );

    tlnvf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (push_cmd),
        .i_pop   (q_pop),
        .o_rdata (pop_cmd),
        .o_stat  (q_stat)
    );

    tlnvf_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_cmd    (pop_cmd),
        .i_q_stat (q_stat),
        .o_pop    (q_pop),
        .o_valid  (o_out.valid),
        .i_ready  (o_out.ready),
        .o_byte   (o_out.out_byte),
        .o_last   (o_out.last_of_run)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("queue read while empty");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> q_stat.empty && !o_out.valid)
        else $error("queue or output not cleared by reset");

endmodule
`default_nettype wire

// ----- tb/text_line_number_visualize_filter_test.sv -----
// Self-checking testbench for the line numbering and visualizing text filter.
`timescale 1ns / 1ps

module text_line_number_visualize_filter_test
    import tlnvf_pkg::*;
;

    localparam int CHUNK_LIMIT = BUFFER_BYTES_DEF;
    localparam int SETTLE      = 20;
    localparam int HOLD_CYCLES = 200;
    localparam int LIMIT_NS    = 2_000_000;

    // Tracks the filter's options and line state and keeps the characters still owed.
    class char_stream_scoreboard;
        t_cfg        opts;
        logic [23:0] line_bcd;
        bit          prev_blank;
        int unsigned chunk_len;
        logic [8:0]  expected_chars[$];   // {last_of_run, out_byte}
        int unsigned mismatches;
        int unsigned bytes_taken;
        int unsigned chars_checked;

        function new();
            opts          = '0;
            line_bcd      = 24'h000001;
            prev_blank    = 1'b0;
            chunk_len     = 0;
            mismatches    = 0;
            bytes_taken   = 0;
            chars_checked = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            mismatches++;
        endtask

        function void note_text_byte(logic [7:0] b, logic first);
            logic [7:0] run[$];
            logic [3:0] dig;
            logic [6:0] low;
            bit         lead;
            bit         blank;
            bit         numbered;
            int         d;
            bytes_taken++;
            if (first) begin
                prev_blank = 1'b0;
                chunk_len  = 0;
            end
            if (chunk_len == 0) begin
                blank = (b == CH_NL);
                // repeated empty line: nothing comes out, position stays at chunk start
                if (opts.squeeze_blank && blank && prev_blank) begin
                    return;
                end
                numbered = opts.number_nonblank ? !blank : opts.number_all;
                if (numbered) begin
                    lead = 1'b1;
                    for (d = 5; d >= 0; d--) begin
                        dig = line_bcd[4*d +: 4];
                        if (dig != 4'd0 || d == 0) begin
                            lead = 1'b0;
                        end
                        run.push_back(lead ? 8'(" ") : 8'("0") + {4'd0, dig});
                    end
                    run.push_back(CH_TAB);
                    // decimal increment, sticks at 999999
                    if (line_bcd != 24'h999999) begin
                        d = 0;
                        while (line_bcd[4*d +: 4] == 4'd9) begin
                            line_bcd[4*d +: 4] = 4'd0;
                            d++;
                        end
                        line_bcd[4*d +: 4] = line_bcd[4*d +: 4] + 4'd1;
                    end
                end
                prev_blank = blank;
            end

            if (b == CH_TAB && opts.show_tabs) begin
                run.push_back("^");
                run.push_back("I");
            end else if (b == CH_NL) begin
                if (opts.show_ends) begin
                    run.push_back("$");
                end
                run.push_back(CH_NL);
            end else if (opts.show_nonprint && b != CH_TAB) begin
                if (b[7]) begin
                    run.push_back("M");
                    run.push_back("-");
                end
                low = b[6:0];
                if (low == 7'h7F) begin
                    run.push_back("^");
                    run.push_back("?");
                end else if (low < 7'd32) begin
                    run.push_back("^");
                    run.push_back({1'b0, low} + 8'd64);
                end else begin
                    run.push_back({1'b0, low});
                end
            end else begin
                run.push_back(b);
            end

            if (b == CH_NL) begin
                chunk_len = 0;
            end else begin
                chunk_len++;
                if (chunk_len >= CHUNK_LIMIT - 1) begin
                    chunk_len = 0;
                end
            end

            foreach (run[i]) begin
                expected_chars.push_back({i == run.size() - 1, run[i]});
            end
        endfunction

        task check_char(logic [7:0] c, logic last);
            logic [8:0] want;
            chars_checked++;
            if (expected_chars.size() == 0) begin
                report($sformatf("unexpected char %02h last=%0b", c, last));
                return;
            end
            want = expected_chars.pop_front();
            if (c !== want[7:0]) begin
                report($sformatf("out_byte %02h, wanted %02h", c, want[7:0]));
            end
            if (last !== want[8]) begin
                report($sformatf("last_of_run %0b, wanted %0b (char %02h)",
                                 last, want[8], want[7:0]));
            end
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    tlnvf_in_if  in_ch();
    tlnvf_out_if out_ch();

    char_stream_scoreboard sb;

    bit sender_idles;
    bit receiver_idles;
    bit hold_request;
    int hold_left;
    int settings_run;

    text_line_number_visualize_filter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    // output side: checks every accepted character, stalls at random or on a hold-off request
    initial begin
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                sb.check_char(out_ch.out_byte, out_ch.last_of_run);
            end
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= !(receiver_idles && $urandom_range(99) < 19);
            end
        end
    end

    task automatic put_reg(t_cfg_idx idx, logic v);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= v;
        @(posedge i_clk);
    endtask

    task automatic load_options(t_cfg c);
        put_reg(CFG_NUMBER_ALL,      c.number_all);
        put_reg(CFG_NUMBER_NONBLANK, c.number_nonblank);
        put_reg(CFG_SQUEEZE_BLANK,   c.squeeze_blank);
        put_reg(CFG_SHOW_ENDS,       c.show_ends);
        put_reg(CFG_SHOW_TABS,       c.show_tabs);
        put_reg(CFG_SHOW_NONPRINT,   c.show_nonprint);
        cfg_we  <= 1'b0;
        sb.opts = c;
        settings_run++;
    endtask

    task automatic offer_byte(logic [7:0] b, logic first);
        while (sender_idles && $urandom_range(99) < 19) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.in_byte       <= b;
        in_ch.first_of_file <= first;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_text_byte(b, first);
    endtask

    // block must be idle before the next option change
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.expected_chars.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [7:0] text_byte();
        int r;
        r = $urandom_range(99);
        if (r < 25) begin
            return CH_NL;
        end else if (r < 33) begin
            return CH_TAB;
        end else if (r < 70) begin
            return 8'($urandom_range(126, 32));
        end
        return 8'($urandom_range(255));
    endfunction

    task automatic random_text(int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < 8) begin
                // run of empty lines for the squeeze logic
                burst = $urandom_range(4, 2);
                repeat (burst) offer_byte(CH_NL, 1'b0);
                sent += burst;
            end else begin
                offer_byte(text_byte(), $urandom_range(99) < 5);
                sent++;
            end
        end
    endtask

    initial begin
        sb           = new();
        settings_run = 0;
        hold_request = 1'b0;
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        i_rst_n  <= 1'b0;
        cfg_we   <= 1'b0;
        cfg_idx  <= CFG_NUMBER_ALL;
        cfg_data <= '0;
        in_ch.valid         <= 1'b0;
        in_ch.in_byte       <= 8'h00;
        in_ch.first_of_file <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // plain pass-through, field extremes
        load_options('{number_all: 1'b0, number_nonblank: 1'b0, squeeze_blank: 1'b0,
                       show_ends: 1'b0, show_tabs: 1'b0, show_nonprint: 1'b0});
        offer_byte(8'h00, 1'b1);
        offer_byte(8'hFF, 1'b0);
        offer_byte(CH_TAB, 1'b0);
        offer_byte(CH_NL, 1'b0);
        offer_byte(8'h7F, 1'b0);
        offer_byte("a", 1'b0);
        drain();

        // every visual form, numbering, squeeze and the new-file reset of blank memory
        load_options('{number_all: 1'b1, number_nonblank: 1'b0, squeeze_blank: 1'b1,
                       show_ends: 1'b1, show_tabs: 1'b1, show_nonprint: 1'b1});
        offer_byte("x", 1'b1);
        offer_byte(CH_NL, 1'b0);
        offer_byte(CH_NL, 1'b0);
        offer_byte(CH_NL, 1'b0);
        offer_byte(CH_NL, 1'b1);
        offer_byte(CH_TAB, 1'b0);
        offer_byte(8'h00, 1'b0);
        offer_byte(8'h1F, 1'b0);
        offer_byte(8'h7F, 1'b0);
        offer_byte(8'h80, 1'b0);
        offer_byte(8'h9F, 1'b0);
        offer_byte(8'hA0, 1'b0);
        offer_byte(8'hFF, 1'b0);
        offer_byte(8'h89, 1'b0);
        offer_byte(8'h8A, 1'b0);
        offer_byte(CH_NL, 1'b0);
        drain();

        // nonblank numbering wins over number-all; raw tab with nonprint on
        load_options('{number_all: 1'b1, number_nonblank: 1'b1, squeeze_blank: 1'b0,
                       show_ends: 1'b0, show_tabs: 1'b0, show_nonprint: 1'b1});
        offer_byte(CH_NL, 1'b0);
        offer_byte("q", 1'b0);
        offer_byte(CH_TAB, 1'b0);
        offer_byte(CH_NL, 1'b0);
        offer_byte(8'hFF, 1'b1);
        drain();

        load_options('1);
        random_text(50);
        drain();

        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        load_options('0);
        random_text(50);
        drain();

        // receiver holds off while requests keep coming, so the queue fills
        receiver_idles = 1'b1;
        load_options(t_cfg'(6'($urandom_range(63))));
        hold_request = 1'b1;
        random_text(50);
        drain();

        sender_idles = 1'b1;
        load_options(t_cfg'(6'($urandom_range(63))));
        random_text(50);
        drain();

        $display("Run covered %0d text bytes and %0d output characters under %0d option sets,",
                 sb.bytes_taken, sb.chars_checked, settings_run);
        $display("including squeezed blank lines, new-file marks and an output hold-off.");
        if (sb.mismatches == 0 && sb.expected_chars.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/tlnvf_pkg.sv
src/tlnvf_in_if.sv
src/tlnvf_out_if.sv
src/tlnvf_front.sv
src/tlnvf_queue.sv
src/tlnvf_back.sv
src/text_line_number_visualize_filter.sv
tb/text_line_number_visualize_filter_test.sv
